// File: src/tlvp_pkg.sv
// tlvp_pkg: shared types and codes of the type-length-value stream parser
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tlvp_pkg;

    localparam int unsigned ApbAddrW  = 3;
    localparam int unsigned ApbDataW  = 32;
    localparam int unsigned LenOctW   = 2;
    localparam int unsigned ByteW     = 8;
    localparam int unsigned LengthW   = 16;
    localparam int unsigned RoleW     = 2;
    localparam int unsigned StatusW   = 2;
    localparam int unsigned InTdataW  = 8;
    localparam int unsigned OutTdataW = 48;

    localparam logic [ApbAddrW-1:0] AddrLengthOctets = 3'd0;
    localparam logic [LenOctW-1:0]  LenOctResetVal   = 2'd1;
    localparam logic [LenOctW-1:0]  LenOctTwo        = 2'd2;

    localparam logic [RoleW-1:0] RoleCode  = 2'd0;
    localparam logic [RoleW-1:0] RoleLen   = 2'd1;
    localparam logic [RoleW-1:0] RoleValue = 2'd2;

    localparam logic [StatusW-1:0] StatOk        = 2'd0;
    localparam logic [StatusW-1:0] StatTruncated = 2'd1;
    localparam logic [StatusW-1:0] StatHeader    = 2'd2;

    typedef struct packed {
        logic [RoleW-1:0]   octet_role;
        logic [ByteW-1:0]   param_code;
        logic [LengthW-1:0] param_length;
        logic [LengthW-1:0] value_index;
        logic               param_done;
        logic               end_of_buffer;
        logic [StatusW-1:0] status;
    } t_result;

endpackage

`default_nettype wire

// File: src/tlvp_in_stage.sv
// tlvp_in_stage: input register of the parser, one word deep
// depends on tlvp_pkg
`timescale 1ns / 1ps
`default_nettype none

module tlvp_in_stage (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [tlvp_pkg::ByteW-1:0] i_data,
    input  wire logic                     i_last,
    input  wire logic                     i_advance,
    output logic                          o_valid,
    output logic [tlvp_pkg::ByteW-1:0]    o_data,
    output logic                          o_last
);

    logic                       r_valid;
    logic [tlvp_pkg::ByteW-1:0] r_data;
    logic                       r_last;

    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
            r_last <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;

endmodule

`default_nettype wire

// File: src/tlvp_decode.sv
// tlvp_decode: parse state, per-word tagging and the result register
// depends on tlvp_pkg
`timescale 1ns / 1ps
`default_nettype none

module tlvp_decode (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic                         i_advance,
    input  wire logic [tlvp_pkg::ByteW-1:0]   i_data,
    input  wire logic                         i_last,
    input  wire logic [tlvp_pkg::LenOctW-1:0] i_length_octets,
    output logic                              o_valid,
    output tlvp_pkg::t_result                 o_result
);

    typedef enum logic [1:0] {
        PH_CODE,
        PH_LEN1,
        PH_LEN2,
        PH_VALUE
    } t_phase;

    t_phase                       r_phase, n_phase;
    logic [tlvp_pkg::ByteW-1:0]   r_code, n_code;
    logic [tlvp_pkg::ByteW-1:0]   r_len_high, n_len_high;
    logic [tlvp_pkg::LengthW-1:0] r_decl_len, n_decl_len;
    logic [tlvp_pkg::LengthW-1:0] r_val_cnt, n_val_cnt;
    logic                         r_out_valid;
    tlvp_pkg::t_result            r_result, n_result;
    logic [tlvp_pkg::LengthW-1:0] w_len_full;
    logic [tlvp_pkg::LengthW-1:0] w_cnt_inc;
    logic                         w_fire;

    assign w_fire     = i_valid && i_advance;
    assign w_cnt_inc  = r_val_cnt + 1'b1;

    always_comb begin
        n_phase    = r_phase;
        n_code     = r_code;
        n_len_high = r_len_high;
        n_decl_len = r_decl_len;
        n_val_cnt  = r_val_cnt;
        w_len_full = '0;
        n_result   = '0;
        n_result.end_of_buffer = i_last;

        unique case (r_phase)
            PH_CODE: begin
                n_result.octet_role = tlvp_pkg::RoleCode;
                n_code     = i_data;
                n_decl_len = '0;
                n_val_cnt  = '0;
                n_len_high = '0;
                n_phase    = PH_LEN1;
            end
            PH_LEN1, PH_LEN2: begin
                n_result.octet_role = tlvp_pkg::RoleLen;
                if (r_phase == PH_LEN1 && i_length_octets == tlvp_pkg::LenOctTwo) begin
                    n_len_high = i_data;
                    n_phase    = PH_LEN2;
                end else begin
                    w_len_full = (r_phase == PH_LEN2) ? {r_len_high, i_data}
                                                      : {{tlvp_pkg::ByteW{1'b0}}, i_data};
                    n_decl_len = w_len_full;
                    n_result.param_length = w_len_full;
                    n_val_cnt  = '0;
                    if (w_len_full == '0) begin
                        n_result.param_done = 1'b1;
                        n_phase = PH_CODE;
                    end else begin
                        n_phase = PH_VALUE;
                    end
                end
            end
            PH_VALUE: begin
                n_result.octet_role   = tlvp_pkg::RoleValue;
                n_result.param_length = r_decl_len;
                n_result.value_index  = r_val_cnt;
                n_val_cnt = w_cnt_inc;
                if (w_cnt_inc >= r_decl_len) begin
                    n_result.param_done = 1'b1;
                    n_phase = PH_CODE;
                end
            end
            default: begin
                n_phase = PH_CODE;
            end
        endcase

        n_result.param_code = n_code;

        if (i_last) begin
            priority if (n_phase == PH_VALUE) begin
                n_result.status = tlvp_pkg::StatTruncated;
            end else if (n_phase == PH_LEN1 || n_phase == PH_LEN2) begin
                n_result.status = tlvp_pkg::StatHeader;
            end else begin
                n_result.status = tlvp_pkg::StatOk;
            end
            n_phase    = PH_CODE;
            n_code     = '0;
            n_len_high = '0;
            n_decl_len = '0;
            n_val_cnt  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_CODE;
            r_code      <= '0;
            r_len_high  <= '0;
            r_decl_len  <= '0;
            r_val_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_advance) begin
                r_out_valid <= i_valid;
            end
            if (w_fire) begin
                r_phase    <= n_phase;
                r_code     <= n_code;
                r_len_high <= n_len_high;
                r_decl_len <= n_decl_len;
                r_val_cnt  <= n_val_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// File: src/tlv_stream_parser.sv
// tlv_stream_parser: top level, stream ports, configuration register, stage wiring
// depends on tlvp_pkg, tlvp_in_stage, tlvp_decode
//
// usage
//   s_axis carries the buffer one octet per word, tlast on its final octet.
//   m_axis returns one word per input word: the octet's role in tuser, its
//   code, declared length, value offset, completion flag and end status in
//   tdata, and tlast copied from the input word.
//   the apb port holds length_octets at address 0 (1 or 2 length octets per
//   parameter); write it only while no word is in flight.
// timing
//   a word passes the input register, then the result register driving m_axis.
//   one word per cycle while m_axis_tready is high; the limit is the state update
//   of phase, length and value counter between input and result registers.
// reset and stall
//   reset empties both registers and sets the parser to expect a code octet;
//   length_octets returns to 1. a buffer's final octet also returns the parse
//   state to expect a code octet.
//   while m_axis_tready is low the result holds; an empty input register takes
//   one more word, then s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module tlv_stream_parser #(
    parameter int unsigned AddrW = tlvp_pkg::ApbAddrW
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [tlvp_pkg::InTdataW-1:0]   s_axis_tdata,   // data_byte
    input  wire logic                            s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // param_code, param_length, value_index, param_done, status, zero pad
    output logic [tlvp_pkg::OutTdataW-1:0]       m_axis_tdata,
    output logic [tlvp_pkg::RoleW-1:0]           m_axis_tuser,   // octet_role
    output logic                                 m_axis_tlast,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [AddrW-1:0]                paddr,
    input  wire logic [tlvp_pkg::ApbDataW-1:0]   pwdata,
    output logic [tlvp_pkg::ApbDataW-1:0]        prdata,
    output logic                                 pready
);

    logic [tlvp_pkg::LenOctW-1:0] r_length_octets;
    logic                         w_advance;
    logic                         w_in_valid;
    logic [tlvp_pkg::ByteW-1:0]   w_in_data;
    logic                         w_in_last;
    tlvp_pkg::t_result            w_result;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length_octets <= tlvp_pkg::LenOctResetVal;
        end else if (psel && penable && pwrite && pready
                     && paddr == AddrW'(tlvp_pkg::AddrLengthOctets)) begin
            r_length_octets <= pwdata[tlvp_pkg::LenOctW-1:0];
        end
    end

    assign prdata = (paddr == AddrW'(tlvp_pkg::AddrLengthOctets))
                  ? {{(tlvp_pkg::ApbDataW-tlvp_pkg::LenOctW){1'b0}}, r_length_octets}
                  : '0;

    assign w_advance = !m_axis_tvalid || m_axis_tready;

    tlvp_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_data    (s_axis_tdata),
        .i_last    (s_axis_tlast),
        .i_advance (w_advance),
        .o_valid   (w_in_valid),
        .o_data    (w_in_data),
        .o_last    (w_in_last)
    );

    tlvp_decode u_dec (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_in_valid),
        .i_advance       (w_advance),
        .i_data          (w_in_data),
        .i_last          (w_in_last),
        .i_length_octets (r_length_octets),
        .o_valid         (m_axis_tvalid),
        .o_result        (w_result)
    );

    assign m_axis_tdata = {5'b0, w_result.status, w_result.param_done, w_result.value_index,
                           w_result.param_length, w_result.param_code};
    assign m_axis_tuser = w_result.octet_role;
    assign m_axis_tlast = w_result.end_of_buffer;

endmodule

`default_nettype wire

// File: src/tlvp_checker.sv
// tlvp_checker: port-level checks of the parser output, bound to the top level
// depends on tlvp_pkg, tlv_stream_parser
`timescale 1ns / 1ps
`default_nettype none

module tlvp_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [tlvp_pkg::OutTdataW-1:0] m_axis_tdata,
    input wire logic [tlvp_pkg::RoleW-1:0]     m_axis_tuser,
    input wire logic                           m_axis_tlast
);

    // status only on the final word
    a_status_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[42:41] == tlvp_pkg::StatOk)
        else $error("status set on a non-final word");

    // code octet never completes a parameter
    a_code_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == tlvp_pkg::RoleCode |-> !m_axis_tdata[40])
        else $error("code octet flagged as completing a parameter");

    // value offset only on value octets
    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != tlvp_pkg::RoleValue |-> m_axis_tdata[39:24] == '0)
        else $error("value offset on a header octet");

    // completing length octet means zero length
    a_len_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == tlvp_pkg::RoleLen && m_axis_tdata[40]
        |-> m_axis_tdata[23:8] == '0)
        else $error("length octet completes a non-empty parameter");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

endmodule

bind tlv_stream_parser tlvp_checker u_tlvp_checker (.*);

`default_nettype wire

// File: test/tlvp_parse_checker.sv
`timescale 1ns / 1ps
// tlvp_parse_checker: watches the octet and result streams of the parser, predicts each
// result word from its own parse state and compares it field by field
// depends on tlvp_pkg
module tlvp_parse_checker
    import tlvp_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_s_tvalid,
    input  wire logic                    i_s_tready,
    input  wire logic [InTdataW-1:0]     i_s_tdata,
    input  wire logic                    i_s_tlast,
    input  wire logic                    i_m_tvalid,
    input  wire logic                    i_m_tready,
    input  wire logic [OutTdataW-1:0]    i_m_tdata,
    input  wire logic [RoleW-1:0]        i_m_tuser,
    input  wire logic                    i_m_tlast,
    input  wire logic                    i_psel,
    input  wire logic                    i_penable,
    input  wire logic                    i_pwrite,
    input  wire logic [ApbAddrW-1:0]     i_paddr,
    input  wire logic [ApbDataW-1:0]     i_pwdata,
    input  wire logic                    i_pready,
    output int                           o_errors,
    output int                           o_pending
);

    localparam int unsigned DoneBit = ByteW + 2 * LengthW;
    localparam int unsigned StatLo  = DoneBit + 1;
    localparam int unsigned PadLo   = StatLo + StatusW;
    localparam int unsigned MaxShown = 40;

    typedef enum logic [1:0] {
        PhCode,
        PhLenFirst,
        PhLenSecond,
        PhValue
    } t_parse_phase;

    t_parse_phase         phase_q = PhCode;
    logic [LenOctW-1:0]   len_width = LenOctResetVal;
    logic [ByteW-1:0]     cur_code = '0;
    logic [ByteW-1:0]     len_high = '0;
    logic [LengthW-1:0]   decl_len = '0;
    logic [LengthW-1:0]   val_count = '0;
    t_result              octet_tags_q[$];
    int                   results_seen = 0;

    initial o_errors = 0;
    initial o_pending = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (o_errors < MaxShown)
            $display("mismatch on result %0d: %s got %0h want %0h", results_seen, what,
                     got, want);
        o_errors++;
    endtask

    task automatic clear_parse();
        phase_q = PhCode;
        cur_code = '0;
        len_high = '0;
        decl_len = '0;
        val_count = '0;
    endtask

    // advance the parse state by one octet and build the tag word it earns
    task automatic parse_octet(input logic [ByteW-1:0] octet, input logic last,
                               output t_result tag);
        logic took_len;
        took_len = 1'b0;
        tag = '0;
        tag.end_of_buffer = last;
        case (phase_q)
            PhCode: begin
                tag.octet_role = RoleCode;
                cur_code = octet;
                decl_len = '0;
                val_count = '0;
                len_high = '0;
                phase_q = PhLenFirst;
            end
            PhLenFirst: begin
                tag.octet_role = RoleLen;
                if (len_width == LenOctTwo) begin
                    len_high = octet;
                    phase_q = PhLenSecond;
                end else begin
                    decl_len = {{(LengthW-ByteW){1'b0}}, octet};
                    took_len = 1'b1;
                end
            end
            PhLenSecond: begin
                tag.octet_role = RoleLen;
                decl_len = {len_high, octet};
                took_len = 1'b1;
            end
            default: begin
                tag.octet_role = RoleValue;
                tag.param_length = decl_len;
                tag.value_index = val_count;
                val_count = val_count + 1'b1;
                if (val_count >= decl_len) begin
                    tag.param_done = 1'b1;
                    phase_q = PhCode;
                end
            end
        endcase
        if (took_len) begin
            tag.param_length = decl_len;
            val_count = '0;
            if (decl_len == '0) begin
                tag.param_done = 1'b1;
                phase_q = PhCode;
            end else begin
                phase_q = PhValue;
            end
        end
        tag.param_code = cur_code;
        if (last) begin
            if (phase_q == PhValue)
                tag.status = StatTruncated;
            else if (phase_q == PhLenFirst || phase_q == PhLenSecond)
                tag.status = StatHeader;
            else
                tag.status = StatOk;
            clear_parse();
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_result tag;
        t_result want;
        if (!i_rst_n) begin
            clear_parse();
            len_width = LenOctResetVal;
            octet_tags_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == AddrLengthOctets)
                len_width = i_pwdata[LenOctW-1:0];
            if (i_s_tvalid && i_s_tready) begin
                parse_octet(i_s_tdata, i_s_tlast, tag);
                octet_tags_q.push_back(tag);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (octet_tags_q.size() == 0) begin
                    report_mismatch("word with none expected", i_m_tdata[31:0], '0);
                end else begin
                    want = octet_tags_q.pop_front();
                    if (i_m_tuser !== want.octet_role)
                        report_mismatch("octet_role", i_m_tuser, want.octet_role);
                    if (i_m_tdata[ByteW-1:0] !== want.param_code)
                        report_mismatch("param_code", i_m_tdata[ByteW-1:0], want.param_code);
                    if (i_m_tdata[ByteW +: LengthW] !== want.param_length)
                        report_mismatch("param_length", i_m_tdata[ByteW +: LengthW],
                                        want.param_length);
                    if (i_m_tdata[ByteW+LengthW +: LengthW] !== want.value_index)
                        report_mismatch("value_index", i_m_tdata[ByteW+LengthW +: LengthW],
                                        want.value_index);
                    if (i_m_tdata[DoneBit] !== want.param_done)
                        report_mismatch("param_done", i_m_tdata[DoneBit], want.param_done);
                    if (i_m_tlast !== want.end_of_buffer)
                        report_mismatch("end_of_buffer", i_m_tlast, want.end_of_buffer);
                    if (i_m_tdata[StatLo +: StatusW] !== want.status)
                        report_mismatch("status", i_m_tdata[StatLo +: StatusW], want.status);
                    if (i_m_tdata[OutTdataW-1:PadLo] !== '0)
                        report_mismatch("pad", i_m_tdata[OutTdataW-1:PadLo], '0);
                end
                results_seen++;
            end
        end
        o_pending = octet_tags_q.size();
    end

endmodule

// File: test/tlv_stream_parser_tb.sv
`timescale 1ns / 1ps
// tlv_stream_parser_tb: drives parameter buffers and register writes into the parser
// depends on tlvp_pkg, tlv_stream_parser, tlvp_parse_checker
module tlv_stream_parser_tb;
    import tlvp_pkg::*;

    localparam int HalfPeriod    = 4;
    localparam int ResetCycles   = 9;
    localparam int QuietLimit    = 2000;
    localparam int HoldCycles    = 80;
    localparam int ItemsPerPhase = 240;
    localparam int NumPhases     = 8;
    localparam int TailCycles    = 4;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [InTdataW-1:0]    s_data = '0;
    logic                   s_last = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [OutTdataW-1:0]   m_data;
    logic [RoleW-1:0]       m_user;
    logic                   m_last;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [ApbAddrW-1:0]    paddr = '0;
    logic [ApbDataW-1:0]    pwdata = '0;
    logic [ApbDataW-1:0]    prdata;
    logic                   pready;
    int                     errors;
    int                     pending;

    bit                     idle_on = 1'b1;
    bit                     hold_req = 1'b0;
    int                     sent = 0;
    logic [LenOctW-1:0]     len_setting = LenOctResetVal;
    logic [ByteW:0]         word_q[$];

    always #(HalfPeriod) i_clk = ~i_clk;

    tlv_stream_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tlast  (s_last),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user),
        .m_axis_tlast  (m_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    tlvp_parse_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .i_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .i_s_tlast  (s_last),
        .i_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .i_m_tdata  (m_data),
        .i_m_tuser  (m_user),
        .i_m_tlast  (m_last),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .i_pready   (pready),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    task automatic send_octet(input logic [ByteW-1:0] octet, input logic last);
        int w;
        w = idle_on ? $urandom_range(0, 3) : 0;
        if (w > 0) begin
            s_valid <= 1'b0;
            repeat (w) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= octet;
        s_last <= last;
        do @(posedge i_clk); while (!(s_valid && s_ready));
        sent++;
    endtask

    // stop offering and wait for every outstanding word to come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TailCycles) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [LenOctW-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= AddrLengthOctets;
        pwdata <= ($urandom() & ~32'h3) | {{(ApbDataW-LenOctW){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        len_setting = value;
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(0, 6);
        if (r < 95)
            return $urandom_range(7, 40);
        return (len_setting == LenOctTwo) ? $urandom_range(41, 300) : $urandom_range(41, 255);
    endfunction

    // header plus nvals value octets, length field per the current setting
    task automatic push_param(input int len, input int nvals);
        logic [ByteW-1:0]   octet;
        logic [LengthW-1:0] len_field;
        len_field = len[LengthW-1:0];
        octet = $urandom_range(0, 255);
        word_q.push_back({1'b0, octet});
        if (len_setting == LenOctTwo)
            word_q.push_back({1'b0, len_field[LengthW-1:ByteW]});
        word_q.push_back({1'b0, len_field[ByteW-1:0]});
        repeat (nvals) begin
            octet = $urandom_range(0, 255);
            word_q.push_back({1'b0, octet});
        end
    endtask

    task automatic make_buffer();
        int kind;
        int n;
        int len;
        logic [ByteW-1:0] octet;
        logic last;
        word_q.delete();
        kind = $urandom_range(0, 19);
        if (kind < 2) begin
            // noise: random octets, final flag anywhere
            n = $urandom_range(1, 10);
            repeat (n) begin
                octet = $urandom_range(0, 255);
                last = ($urandom_range(0, 5) == 0);
                word_q.push_back({last, octet});
            end
        end else begin
            n = $urandom_range(0, 3);
            repeat (n) begin
                len = pick_length();
                push_param(len, len);
            end
            if (kind < 5) begin
                // value cut short
                len = (len_setting == LenOctTwo) ? $urandom_range(1, 65535)
                                                 : $urandom_range(1, 255);
                push_param(len, $urandom_range(0, (len < 4) ? len - 1 : 3));
            end else if (kind < 8) begin
                // header cut short
                octet = $urandom_range(0, 255);
                word_q.push_back({1'b0, octet});
                if (len_setting == LenOctTwo && $urandom_range(0, 1) == 1) begin
                    octet = $urandom_range(0, 255);
                    word_q.push_back({1'b0, octet});
                end
            end
            if (word_q.size() == 0)
                push_param(0, 0);
            word_q[word_q.size()-1][ByteW] = 1'b1;
        end
    endtask

    task automatic send_words();
        foreach (word_q[i])
            send_octet(word_q[i][ByteW-1:0], word_q[i][ByteW]);
    endtask

    initial begin
        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin : receiver
        int w;
        forever begin
            w = idle_on ? $urandom_range(0, 3) : 0;
            if (hold_req) begin
                hold_req = 1'b0;
                w = HoldCycles;
            end
            if (w > 0) begin
                m_ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!(m_valid && m_ready));
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QuietLimit) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL tlv_stream_parser");
        $finish;
    end

    initial begin : stimulus
        logic [LenOctW-1:0] settings [NumPhases];
        int  target;
        bit  held;
        bit  paused;
        logic [ByteW-1:0] octet;
        settings = '{2'd2, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1, 2'd2, 2'd3};
        held = 1'b0;
        paused = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        @(posedge i_clk);

        // one length octet: zero length, clean end, header cut, value cut
        send_octet(8'h00, 1'b0);
        send_octet(8'h00, 1'b1);
        send_octet(8'hFF, 1'b0);
        send_octet(8'h02, 1'b0);
        send_octet(8'hFF, 1'b0);
        send_octet(8'h00, 1'b1);
        send_octet(8'h5A, 1'b1);
        send_octet(8'h01, 1'b0);
        send_octet(8'h03, 1'b0);
        send_octet(8'h11, 1'b1);
        drain();
        apb_write(LenOctTwo);
        // two length octets
        send_octet(8'hA5, 1'b0);
        send_octet(8'h00, 1'b0);
        send_octet(8'h01, 1'b0);
        send_octet(8'h80, 1'b1);
        send_octet(8'h07, 1'b0);
        send_octet(8'hFF, 1'b1);
        send_octet(8'h08, 1'b0);
        send_octet(8'hFF, 1'b0);
        send_octet(8'hFF, 1'b0);
        send_octet(8'h33, 1'b0);
        send_octet(8'h44, 1'b1);
        // width changed after a first length octet: second one still follows
        send_octet(8'h09, 1'b0);
        send_octet(8'h00, 1'b0);
        drain();
        apb_write(LenOctResetVal);
        send_octet(8'h00, 1'b1);
        drain();

        for (int ph = 0; ph < NumPhases; ph++) begin
            apb_write(settings[ph]);
            idle_on = (ph % 3) != 2;
            target = sent + ItemsPerPhase;
            while (sent < target) begin
                make_buffer();
                send_words();
                if (ph == 1 && !held && sent > target - 200) begin
                    hold_req = 1'b1;
                    held = 1'b1;
                end
                if (ph == 4 && !paused && sent > target - 120) begin
                    drain();
                    paused = 1'b1;
                end
            end
            // sometimes leave a header open across the register write
            if ($urandom_range(0, 1) == 1) begin
                octet = $urandom_range(0, 255);
                send_octet(octet, 1'b0);
                if (len_setting == LenOctTwo && $urandom_range(0, 1) == 1) begin
                    octet = $urandom_range(0, 255);
                    send_octet(octet, 1'b0);
                end
            end
            drain();
        end

        if (errors == 0 && pending == 0)
            $display("PASS tlv_stream_parser");
        else
            $display("FAIL tlv_stream_parser");
        $finish;
    end

endmodule

// File: sim.f
src/tlvp_pkg.sv
src/tlvp_in_stage.sv
src/tlvp_decode.sv
src/tlv_stream_parser.sv
src/tlvp_checker.sv
test/tlvp_parse_checker.sv
test/tlv_stream_parser_tb.sv
